/* rtl/saturation_agc_with_channel_trim_unit_macros.svh */
// assertion macros shared by the checker of the agc unit
// each macro expects clk and rst_n in the scope where it is used
`ifndef SATURATION_AGC_WITH_CHANNEL_TRIM_UNIT_MACROS_SVH
`define SATURATION_AGC_WITH_CHANNEL_TRIM_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SAGC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sagc check failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define SAGC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sagc check failed: next-cycle implication");

`endif

/* rtl/sagc_pkg.sv */
// shared types and constants for the saturation agc unit
// no dependencies; imported by every other file of the block but sagc_ram and the macro header
`timescale 1ns / 1ps
`default_nettype none

package sagc_pkg;

  // field widths
  localparam int OPCODE_W   = 2;
  localparam int TRIM_IDX_W = 4;
  localparam int TRIM_W     = 8;
  localparam int GAIN_W     = 7;
  localparam int HOLD_W     = 8;
  localparam int EVT_W      = 32;
  localparam int CHAN_W     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // reset values of loop state and registers
  localparam logic [GAIN_W-1:0] BASE_GAIN_RST  = 7'd30;
  localparam logic [GAIN_W-1:0] STEP_DOWN_RST  = 7'd4;
  localparam logic [GAIN_W-1:0] STEP_UP_RST    = 7'd1;
  localparam logic [GAIN_W-1:0] FLOOR_RST      = 7'd0;
  localparam logic [GAIN_W-1:0] CEIL_RST       = 7'd127;
  localparam logic [HOLD_W-1:0] HOLD_LIMIT_RST = 8'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_DOWN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_UP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CEILING    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_LIMIT = 3'd5;

  typedef enum logic [OPCODE_W-1:0] {
    OP_FRAME   = 2'd0,
    OP_TRIM_WR = 2'd1,
    OP_CLEAR   = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic trim_wr;
    logic clear;
    logic update;
    logic load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    opcode_t op;
    logic    slot_free;
    logic    last_ch;
  } sts_t;

endpackage

`default_nettype wire

/* rtl/sagc_in_if.sv */
// request channel into the agc unit: frame, trim write or counter clear
// depends on sagc_pkg
`timescale 1ns / 1ps
`default_nettype none

interface sagc_in_if import sagc_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic [OPCODE_W-1:0]          opcode;
  logic                         saturated_in;
  logic [TRIM_IDX_W-1:0]        trim_index;
  logic signed [TRIM_W-1:0]     trim_value;

  modport source (output valid, opcode, saturated_in, trim_index, trim_value,
                  input ready);
  modport sink   (input valid, opcode, saturated_in, trim_index, trim_value,
                  output ready);
  modport mon    (input valid, ready, opcode, saturated_in, trim_index, trim_value);
endinterface

`default_nettype wire

/* rtl/sagc_out_if.sv */
// result channel of the agc unit: one channel gain per channel of a frame request
// depends on sagc_pkg
`timescale 1ns / 1ps
`default_nettype none

interface sagc_out_if import sagc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] channel;
  logic [GAIN_W-1:0] channel_gain;
  logic              last;
  logic [GAIN_W-1:0] base_gain_out;
  logic              saturated_out;
  logic [EVT_W-1:0]  event_count_out;

  modport source (output valid, channel, channel_gain, last, base_gain_out,
                  saturated_out, event_count_out, input ready);
  modport sink   (input valid, channel, channel_gain, last, base_gain_out,
                  saturated_out, event_count_out, output ready);
  modport mon    (input valid, ready, channel, channel_gain, last, base_gain_out,
                  saturated_out, event_count_out);
endinterface

`default_nettype wire

/* rtl/sagc_cfg_if.sv */
// configuration write channel of the agc unit
// depends on sagc_pkg
`timescale 1ns / 1ps
`default_nettype none

interface sagc_cfg_if import sagc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/saturation_agc_with_channel_trim_unit.sv */
// top level of the saturation agc unit with per-channel trim
// depends on sagc_pkg, the channel interfaces, sagc_ctrl and sagc_dp
`timescale 1ns / 1ps
`default_nettype none

// Outer-loop receive AGC. A frame request (opcode 0) updates the base gain
// from its saturation flag when enabled, then returns NUM_CHANNELS results,
// one per channel, each the base gain plus that channel's signed trim,
// clamped to the floor and ceiling registers. Trim writes and counter clears
// return nothing. Timing: every request is executed in the cycle after it
// is taken; a frame then streams one result per cycle while the sink is
// ready. The channel counter walks the trim RAM one entry per loaded
// result through its single read port. One request is worked at a time;
// the next request is taken while the final result still waits in the
// output register. Configuration writes are always taken.

module saturation_agc_with_channel_trim_unit import sagc_pkg::*; #(
  parameter int NUM_CHANNELS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  sagc_in_if.sink   in_chan,
  sagc_out_if.source out_chan,
  sagc_cfg_if.sink  cfg_chan
);

  cmd_t cmd;
  sts_t sts;

  // sequencing
  sagc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // registers, loop state, trim store and output register
  sagc_dp #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_opcode        (in_chan.opcode),
    .in_saturated     (in_chan.saturated_in),
    .in_trim_index    (in_chan.trim_index),
    .in_trim_value    (in_chan.trim_value),
    .cfg_valid        (cfg_chan.valid),
    .cfg_ready        (cfg_chan.ready),
    .cfg_index        (cfg_chan.index),
    .cfg_data         (cfg_chan.data),
    .out_valid        (out_chan.valid),
    .out_ready        (out_chan.ready),
    .out_channel      (out_chan.channel),
    .out_channel_gain (out_chan.channel_gain),
    .out_last         (out_chan.last),
    .out_base_gain    (out_chan.base_gain_out),
    .out_saturated    (out_chan.saturated_out),
    .out_event_count  (out_chan.event_count_out)
  );

endmodule

`default_nettype wire

/* rtl/sagc_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module sagc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* rtl/sagc_ctrl.sv */
// controller state machine of the agc unit
// depends on sagc_pkg; drives commands into sagc_dp
`timescale 1ns / 1ps
`default_nettype none

module sagc_ctrl import sagc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts.op == OP_FRAME) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (sts.slot_free && sts.last_ch) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_EXEC: begin
        case (sts.op)
          OP_FRAME:   cmd.update  = 1'b1;
          OP_TRIM_WR: cmd.trim_wr = 1'b1;
          OP_CLEAR:   cmd.clear   = 1'b1;
          default:    cmd         = '0;
        endcase
      end
      ST_EMIT: begin
        cmd.load = sts.slot_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/sagc_dp.sv */
// datapath of the agc unit: registers, loop state, trim ram, channel walk
// depends on sagc_pkg and sagc_ram; commanded by sagc_ctrl
`timescale 1ns / 1ps
`default_nettype none

module sagc_dp import sagc_pkg::*; #(
  parameter int NUM_CHANNELS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire cmd_t                     cmd,
  output sts_t                          sts,
  // request payload
  input  wire logic [OPCODE_W-1:0]      in_opcode,
  input  wire logic                     in_saturated,
  input  wire logic [TRIM_IDX_W-1:0]    in_trim_index,
  input  wire logic signed [TRIM_W-1:0] in_trim_value,
  // configuration writes
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [CFG_DATA_W-1:0]    cfg_data,
  // result channel
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [CHAN_W-1:0]             out_channel,
  output logic [GAIN_W-1:0]             out_channel_gain,
  output logic                          out_last,
  output logic [GAIN_W-1:0]             out_base_gain,
  output logic                          out_saturated,
  output logic [EVT_W-1:0]              out_event_count
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // configuration registers
  logic              enable_r;
  logic [GAIN_W-1:0] step_down_r;
  logic [GAIN_W-1:0] step_up_r;
  logic [GAIN_W-1:0] floor_r;
  logic [GAIN_W-1:0] ceil_r;
  logic [HOLD_W-1:0] hold_limit_r;

  // captured request
  opcode_t                  op_r;
  logic                     sat_r;
  logic [TRIM_IDX_W-1:0]    tidx_r;
  logic signed [TRIM_W-1:0] tval_r;

  // loop state
  logic [GAIN_W-1:0] base_r, base_nxt;
  logic [HOLD_W-1:0] hold_r, hold_nxt;
  logic              last_sat_r, last_sat_nxt;
  logic [EVT_W-1:0]  evt_r, evt_nxt;

  // channel walk and trim store
  logic [IDX_W-1:0]        cnt_r, cnt_nxt;
  logic [IDX_W-1:0]        rd_addr;
  logic [IDX_W-1:0]        wr_addr;
  logic [31:0]             tidx_ext;
  logic [31:0]             cnt_ext;
  logic                    wr_ok;
  logic                    wr_en;
  logic [NUM_CHANNELS-1:0] vld_r;
  logic                    vld_rd_r;
  logic [TRIM_W-1:0]       ram_rd;
  logic signed [TRIM_W-1:0] trim_eff;

  // arithmetic
  logic [GAIN_W:0]         down_lim;
  logic [GAIN_W:0]         up_sum;
  logic [HOLD_W-1:0]       hold_inc;
  logic signed [GAIN_W+1:0] raw_gain;
  logic [GAIN_W-1:0]       ch_gain;

  // output register
  logic              out_valid_r;
  logic [CHAN_W-1:0] out_channel_r;
  logic [GAIN_W-1:0] out_gain_r;
  logic              out_last_r;
  logic [GAIN_W-1:0] out_base_r;
  logic              out_sat_r;
  logic [EVT_W-1:0]  out_evt_r;
  logic              slot_free;

  // configuration port, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= 1'b0;
      step_down_r  <= STEP_DOWN_RST;
      step_up_r    <= STEP_UP_RST;
      floor_r      <= FLOOR_RST;
      ceil_r       <= CEIL_RST;
      hold_limit_r <= HOLD_LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ENABLE:     enable_r     <= cfg_data[0];
        CFG_STEP_DOWN:  step_down_r  <= cfg_data[GAIN_W-1:0];
        CFG_STEP_UP:    step_up_r    <= cfg_data[GAIN_W-1:0];
        CFG_FLOOR:      floor_r      <= cfg_data[GAIN_W-1:0];
        CFG_CEILING:    ceil_r       <= cfg_data[GAIN_W-1:0];
        CFG_HOLD_LIMIT: hold_limit_r <= cfg_data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= opcode_t'(in_opcode);
      sat_r  <= in_saturated;
      tidx_r <= in_trim_index;
      tval_r <= in_trim_value;
    end
  end

  // attack / release arithmetic
  assign down_lim = {1'b0, step_down_r} + {1'b0, floor_r};
  assign up_sum   = {1'b0, base_r} + {1'b0, step_up_r};
  assign hold_inc = hold_r + 8'd1;

  always_comb begin
    base_nxt     = base_r;
    hold_nxt     = hold_r;
    last_sat_nxt = last_sat_r;
    evt_nxt      = evt_r;
    if (cmd.clear) begin
      hold_nxt     = '0;
      last_sat_nxt = 1'b0;
      evt_nxt      = '0;
    end else if (cmd.update && enable_r) begin
      last_sat_nxt = sat_r;
      if (sat_r) begin
        evt_nxt  = evt_r + 32'd1;
        hold_nxt = '0;
        if ({1'b0, base_r} >= down_lim) begin
          base_nxt = base_r - step_down_r;
        end else begin
          base_nxt = floor_r;
        end
      end else if (hold_inc >= hold_limit_r) begin
        hold_nxt = '0;
        if (up_sum <= {1'b0, ceil_r}) begin
          base_nxt = up_sum[GAIN_W-1:0];
        end else begin
          base_nxt = ceil_r;
        end
      end else begin
        hold_nxt = hold_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r     <= BASE_GAIN_RST;
      hold_r     <= '0;
      last_sat_r <= 1'b0;
      evt_r      <= '0;
    end else begin
      base_r     <= base_nxt;
      hold_r     <= hold_nxt;
      last_sat_r <= last_sat_nxt;
      evt_r      <= evt_nxt;
    end
  end

  // trim write address, indexes beyond the channel count are dropped
  assign tidx_ext = 32'(tidx_r);
  assign wr_ok    = (tidx_ext < NUM_CHANNELS);
  assign wr_addr  = tidx_ext[IDX_W-1:0];
  assign wr_en    = cmd.trim_wr && wr_ok;

  // channel counter, read address runs one ahead when a result is loaded
  assign rd_addr = cmd.load ? (cnt_r + IDX_W'(1)) : cnt_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.capture) begin
      cnt_nxt = '0;
    end else if (cmd.load) begin
      cnt_nxt = cnt_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // valid bits stand in for the cleared trim store after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (32'(rd_addr) < NUM_CHANNELS) begin
      vld_rd_r <= vld_r[rd_addr];
    end else begin
      vld_rd_r <= 1'b0;
    end
  end

  sagc_ram #(
    .WIDTH (TRIM_W),
    .DEPTH (NUM_CHANNELS),
    .AW    (IDX_W)
  ) u_trim_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (tval_r),
    .rd_addr (rd_addr),
    .rd_data (ram_rd)
  );

  // channel gain: base plus signed trim, clamped floor first
  assign trim_eff = vld_rd_r ? signed'(ram_rd) : '0;
  assign raw_gain = signed'({2'b00, base_r}) + signed'({trim_eff[TRIM_W-1], trim_eff});

  always_comb begin
    if (raw_gain < signed'({2'b00, floor_r})) begin
      ch_gain = floor_r;
    end else if (raw_gain > signed'({2'b00, ceil_r})) begin
      ch_gain = ceil_r;
    end else begin
      ch_gain = raw_gain[GAIN_W-1:0];
    end
  end

  // output register
  assign slot_free = !out_valid_r || out_ready;
  assign cnt_ext   = 32'(cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_channel_r <= cnt_ext[CHAN_W-1:0];
      out_gain_r    <= ch_gain;
      out_last_r    <= sts.last_ch;
      out_base_r    <= base_r;
      out_sat_r     <= last_sat_r;
      out_evt_r     <= evt_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_channel      = out_channel_r;
  assign out_channel_gain = out_gain_r;
  assign out_last         = out_last_r;
  assign out_base_gain    = out_base_r;
  assign out_saturated    = out_sat_r;
  assign out_event_count  = out_evt_r;

  // status to controller
  assign sts.op        = op_r;
  assign sts.slot_free = slot_free;
  assign sts.last_ch   = (cnt_r == IDX_W'(NUM_CHANNELS - 1));

endmodule

`default_nettype wire

/* rtl/sagc_chk.sv */
// port-level checker for the agc unit, bound to the top level
// depends on sagc_pkg, the channel interfaces and the assertion macros
`timescale 1ns / 1ps
`default_nettype none

`include "saturation_agc_with_channel_trim_unit_macros.svh"

module sagc_chk import sagc_pkg::*; (
  input wire logic   clk,
  input wire logic   rst_n,
  sagc_in_if.sink    in_chan,
  sagc_out_if.source out_chan
);

  logic                                 in_acc;
  logic                                 out_acc;
  logic                                 out_stall;
  logic [CHAN_W+2*GAIN_W+EVT_W+1:0]     out_payload;

  assign in_acc    = in_chan.valid && in_chan.ready;
  assign out_acc   = out_chan.valid && out_chan.ready;
  assign out_stall = out_chan.valid && !out_chan.ready;

  // all result fields side by side
  assign out_payload = {out_chan.channel, out_chan.channel_gain, out_chan.last,
                        out_chan.base_gain_out, out_chan.saturated_out,
                        out_chan.event_count_out};

  // a stalled result stays offered
  `SAGC_ASSERT_NEXT(a_out_hold, out_stall, out_chan.valid)

  // a stalled result keeps its payload
  `SAGC_ASSERT_NEXT(a_out_stable, out_stall, $stable(out_payload))

  // a frame request blocks further requests while it executes
  `SAGC_ASSERT_NEXT(a_frame_busy, in_acc && (in_chan.opcode == OP_FRAME), !in_chan.ready)

  // results of one frame follow back to back while the sink takes them
  `SAGC_ASSERT_NEXT(a_run_dense, out_acc && !out_chan.last, out_chan.valid)

  // no new request is taken in the middle of a frame run
  `SAGC_ASSERT_SAME(a_run_excl, out_chan.valid && !out_chan.last, !in_chan.ready)

endmodule

bind saturation_agc_with_channel_trim_unit sagc_chk u_sagc_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_chan  (in_chan),
  .out_chan (out_chan)
);

`default_nettype wire
